// ----- hdl/pps_pkg.sv -----
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; imported by the top level.
package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;
  localparam int SLOT_W    = 4;
  localparam int PRIO_W    = 8;
  localparam int REM_W     = 16;
  localparam int CNT_W     = 5;
  localparam int SLOT_AW   = $clog2(MAX_TASKS);
  localparam int SCAN_W    = $clog2(MAX_TASKS + 1);

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [CNT_W-1:0]     DONE_MAX = {CNT_W{1'b1}};

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [TIME_BITS-1:0] arrive;
    logic [REM_W-1:0]     rem;
  } task_entry_t;

  localparam int ENTRY_W = $bits(task_entry_t);

endpackage

// ----- hdl/pps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/preemptive_priority_scheduler_unit.sv -----
// Preemptive priority scheduler: a task table in RAM scanned one slot per cycle.
// Depends on pps_pkg and pps_ram.
//
// A load transaction (in_tuser = 0) writes one slot's priority, arrival time and
// burst. A tick transaction (in_tuser = 1) occupies the block until its result
// is registered: the task table RAM is read one slot per cycle and a single
// comparator keeps the best ready candidate, taking each slot's registered read
// data and ending the scan once the last read has drained, then the winner's
// remaining work is written back and the result is registered. Active counts
// above sixteen scan sixteen slots. Results wait in an output register; a tick
// finishing while the previous result is still held stalls until it is taken.
// The user must write the configuration register through cfg_valid/cfg_ready
// only while the block is idle; the block itself does not enforce this. After
// reset all slots hold no work; each slot's priority and arrival time are
// undefined until loaded.
module preemptive_priority_scheduler_unit
  import pps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,     // active_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,     // slot[3:0], prio[11:4], arrive_at[27:12], burst[43:28]
  input  logic [0:0]  in_tuser,     // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // ran_slot[3:0], finished[4], time_now[20:5], all_done[21]
  output logic [0:0]  out_tuser     // idle
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [SCAN_W-1:0]    cnt_r, cnt_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [SLOT_AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic                 found_r, found_nxt;
  logic [SLOT_AW-1:0]   best_idx_r, best_idx_nxt;
  task_entry_t          best_r, best_nxt;
  logic [TIME_BITS-1:0] clock_r, clock_nxt;
  logic [CNT_W-1:0]     done_r, done_nxt;
  logic [4:0]           active_r, active_nxt;
  logic [MAX_TASKS-1:0] valid_r, valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [23:0]          out_data_r, out_data_nxt;
  logic                 out_idle_r, out_idle_nxt;

  logic [SCAN_W-1:0]    n_slots;
  logic                 in_acc;
  logic                 ram_we;
  logic [SLOT_AW-1:0]   ram_waddr;
  task_entry_t          ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  task_entry_t          cand;
  logic                 cand_ok;
  logic                 take;
  logic                 fin_fire;
  logic                 finished;
  logic                 all_done;

  pps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[SLOT_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_idle_r;

  // Clamp the active count to the table depth.
  assign n_slots = (active_r > 5'(MAX_TASKS)) ? SCAN_W'(MAX_TASKS) : SCAN_W'(active_r);

  // Shared compare unit: one candidate against the best so far.
  assign cand    = task_entry_t'(ram_rdata);
  assign cand_ok = rd_vld_r && valid_r[rd_idx_r] && (cand.arrive <= clock_r) &&
                   (cand.rem != '0);
  assign take    = cand_ok && (!found_r || (cand.prio < best_r.prio));

  assign fin_fire = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  assign finished = found_r && (best_r.rem == REM_W'(1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_tdata[SLOT_AW-1:0];
    ram_wdata.prio   = in_tdata[11:4];
    ram_wdata.arrive = in_tdata[27:12];
    ram_wdata.rem    = in_tdata[43:28];
    if (in_acc && (in_tuser[0] == FUNC_LOAD)) begin
      ram_we = 1'b1;
    end else if (fin_fire && found_r) begin
      ram_we        = 1'b1;
      ram_waddr     = best_idx_r;
      ram_wdata     = best_r;
      ram_wdata.rem = best_r.rem - REM_W'(1);
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (fin_fire && finished && (done_r != DONE_MAX)) begin
      done_nxt = done_r + CNT_W'(1);
    end
  end

  assign all_done = (SCAN_W'(done_nxt) >= n_slots);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    clock_nxt     = clock_r;
    active_nxt    = active_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_idle_nxt  = out_idle_r;

    if (cfg_valid) begin
      active_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == FUNC_LOAD) begin
            valid_nxt[in_tdata[SLOT_AW-1:0]] = 1'b1;
          end else begin
            state_nxt  = ST_SCAN;
            cnt_nxt    = '0;
            rd_vld_nxt = 1'b0;
            found_nxt  = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        rd_idx_nxt = cnt_r[SLOT_AW-1:0];
        if (cnt_r < n_slots) begin
          cnt_nxt    = cnt_r + SCAN_W'(1);
          rd_vld_nxt = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (take) begin
          found_nxt    = 1'b1;
          best_idx_nxt = rd_idx_r;
          best_nxt     = cand;
        end
        if ((cnt_r >= n_slots) && !rd_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free.
        if (fin_fire) begin
          if (clock_r != TIME_MAX) begin
            clock_nxt = clock_r + TIME_BITS'(1);
          end
          out_valid_nxt = 1'b1;
          out_idle_nxt  = !found_r;
          out_data_nxt  = '0;
          out_data_nxt[3:0]  = found_r ? SLOT_W'(best_idx_r) : '0;
          out_data_nxt[4]    = finished;
          out_data_nxt[20:5] = (clock_r != TIME_MAX) ? clock_r + TIME_BITS'(1) : clock_r;
          out_data_nxt[21]   = all_done;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      clock_r     <= '0;
      done_r      <= '0;
      active_r    <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      clock_r     <= clock_nxt;
      done_r      <= done_nxt;
      active_r    <= active_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
    out_idle_r <= out_idle_nxt;
  end

endmodule

// ----- bench/tb_preemptive_priority_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the preemptive priority scheduler: predicts every tick result
// from its own task table copy and checks each out transaction field by field.
// Depends on pps_pkg and the RTL top level preemptive_priority_scheduler_unit.
module tb_preemptive_priority_scheduler_unit
  import pps_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic                 idle;
    logic                 finished;
    logic [TIME_BITS-1:0] time_now;
    logic                 all_done;
  } tick_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;

  preemptive_priority_scheduler_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Scheduler state as predicted by the bench
  logic [PRIO_W-1:0]    sched_prio   [MAX_TASKS];
  logic [TIME_BITS-1:0] sched_arrive [MAX_TASKS];
  logic [REM_W-1:0]     sched_left   [MAX_TASKS];
  logic [TIME_BITS-1:0] sched_clock;
  logic [CNT_W-1:0]     sched_done;
  logic [4:0]           sched_active;

  tick_result_t expected_ticks[$];
  int mismatch_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int slots_used();
    return (int'(sched_active) > MAX_TASKS) ? MAX_TASKS : int'(sched_active);
  endfunction

  // Pick the ready task with the lowest priority value, run it one time unit.
  function automatic tick_result_t schedule_tick();
    tick_result_t      r;
    int                n;
    bit                found;
    logic [SLOT_W-1:0] best;
    logic [PRIO_W-1:0] best_prio;
    n = slots_used();
    found = 1'b0;
    best = '0;
    best_prio = '0;
    r = '0;
    for (int i = 0; i < n; i++) begin
      if (sched_arrive[i] <= sched_clock && sched_left[i] != '0) begin
        if (!found || sched_prio[i] < best_prio) begin
          found = 1'b1;
          best = SLOT_W'(i);
          best_prio = sched_prio[i];
        end
      end
    end
    if (found) begin
      sched_left[best] = sched_left[best] - REM_W'(1);
      if (sched_left[best] == '0) begin
        r.finished = 1'b1;
        if (sched_done != DONE_MAX) sched_done = sched_done + CNT_W'(1);
      end
    end
    if (sched_clock != TIME_MAX) sched_clock = sched_clock + TIME_BITS'(1);
    r.slot = found ? best : '0;
    r.idle = !found;
    r.time_now = sched_clock;
    r.all_done = (int'(sched_done) >= n);
    return r;
  endfunction

  // Offer one transaction; valid stays high afterwards unless a gap follows.
  task automatic issue_request(input logic func, input logic [3:0] slot,
                               input logic [7:0] prio, input logic [15:0] arrive,
                               input logic [15:0] burst);
    int gap;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'b0, burst, arrive, prio, slot};
    do @(posedge clk); while (!in_tready);
    if (func == FUNC_TICK) begin
      expected_ticks.push_back(schedule_tick());
    end else begin
      sched_prio[slot]   = prio;
      sched_arrive[slot] = arrive;
      sched_left[slot]   = burst;
    end
  endtask

  task automatic load_task(input logic [3:0] slot, input logic [7:0] prio,
                           input logic [15:0] arrive, input logic [15:0] burst);
    issue_request(FUNC_LOAD, slot, prio, arrive, burst);
  endtask

  task automatic advance_time();
    issue_request(FUNC_TICK, 4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Drop valid and wait until every predicted tick has come out.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sched_active = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] near_arrival(input int spread);
    int t;
    t = int'(sched_clock) + $urandom_range(0, spread);
    return (t > int'(TIME_MAX)) ? TIME_MAX : 16'(t);
  endfunction

  task automatic random_load();
    logic [3:0]  slot;
    logic [7:0]  prio;
    logic [15:0] arrive;
    logic [15:0] burst;
    int          roll;
    slot = ($urandom_range(99) < 85 && slots_used() > 0) ?
           4'($urandom_range(0, slots_used() - 1)) : 4'($urandom_range(0, 15));
    // narrow priorities make ties common
    prio = ($urandom_range(1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 80)      arrive = near_arrival(20);
    else if (roll < 90) arrive = 16'($urandom);
    else                arrive = '0;
    roll = $urandom_range(99);
    if (roll < 70)      burst = 16'($urandom_range(1, 6));
    else if (roll < 80) burst = '0;
    else if (roll < 95) burst = 16'($urandom_range(1, 40));
    else                burst = 16'($urandom);
    load_task(slot, prio, arrive, burst);
  endtask

  task automatic test_directed();
    advance_time();                 // nothing active: idle, all done
    settle();
    write_active(5'd5);
    load_task(4'd0, 8'd255, 16'd0, 16'd1);
    load_task(4'd1, 8'd0, 16'hFFFF, 16'hFFFF);   // never arrives here
    load_task(4'd2, 8'd7, 16'd0, 16'd2);
    load_task(4'd3, 8'd7, 16'd0, 16'd1);         // ties with slot 2
    load_task(4'd4, 8'd0, 16'd0, 16'd0);         // zero burst, never ready
    repeat (5) advance_time();
    load_task(4'd4, 8'd0, 16'd0, 16'd1);
    advance_time();
    // preemption: a better task arrives while slot 0 is running
    load_task(4'd0, 8'd200, 16'd0, 16'd5);
    load_task(4'd1, 8'd0, near_arrival(0) + 16'd2, 16'd3);
    repeat (6) advance_time();
    settle();
    write_active(5'd16);
    load_task(4'd15, 8'd128, 16'd0, 16'd3);
    advance_time();
    settle();
    write_active(5'd31);            // acts as sixteen slots
    advance_time();
    settle();
  endtask

  task automatic test_backpressure();
    write_active(5'd16);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    for (int s = 0; s < MAX_TASKS; s++)
      load_task(4'(s), 8'($urandom_range(0, 7)), near_arrival(4), 16'($urandom_range(1, 4)));
    rx_hold = 400;
    repeat (40) advance_time();
    settle();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [4:0] active, input int count);
    write_active(active);
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    for (int s = 0; s < slots_used(); s++)
      load_task(4'(s), 8'($urandom_range(0, 15)), near_arrival(10), 16'($urandom_range(1, 8)));
    repeat (count) begin
      if ($urandom_range(99) < 35) random_load();
      else advance_time();
    end
    settle();
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    tick_result_t seen;
    tick_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.slot     = out_tdata[3:0];
      seen.finished = out_tdata[4];
      seen.time_now = out_tdata[20:5];
      seen.all_done = out_tdata[21];
      seen.idle     = out_tuser[0];
      if (expected_ticks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: slot %0d idle %0b fin %0b time %0d all_done %0b",
                   seen.slot, seen.idle, seen.finished, seen.time_now, seen.all_done);
      end else begin
        want = expected_ticks.pop_front();
        if (seen.slot != want.slot || seen.idle != want.idle ||
            seen.finished != want.finished || seen.time_now != want.time_now ||
            seen.all_done != want.all_done) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch at %0t: exp slot %0d idle %0b fin %0b time %0d all_done %0b, %s",
                     $realtime, want.slot, want.idle, want.finished, want.time_now,
                     want.all_done,
                     $sformatf("got slot %0d idle %0b fin %0b time %0d all_done %0b",
                               seen.slot, seen.idle, seen.finished, seen.time_now,
                               seen.all_done));
        end
      end
    end
  end

  // Watchdog: count cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("[preemptive_priority_scheduler_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    for (int s = 0; s < MAX_TASKS; s++) begin
      sched_prio[s]   = '0;
      sched_arrive[s] = '0;
      sched_left[s]   = '0;
    end
    sched_clock  = '0;
    sched_done   = '0;
    sched_active = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_traffic(0, 0, 5'd16, 450);
    test_random_traffic(49, 0, 5'($urandom_range(2, 15)), 450);
    test_random_traffic(0, 49, 5'd1, 450);
    test_random_traffic(24, 24, 5'd31, 450);

    if (mismatch_count == 0 && expected_ticks.size() == 0) begin
      $display("[preemptive_priority_scheduler_unit] OK");
    end else begin
      $display("[preemptive_priority_scheduler_unit] ERROR");
    end
    $finish;
  end

endmodule
